// ===== src/rase_pkg.sv =====
package rase_pkg;

   localparam int DATA_W      = 32;
   localparam int STAMP_WIDTH = 32;
   localparam int SCALE_W     = 24;
   localparam int COUNT_W     = 16;
   localparam int ANGLE_W     = 9;
   localparam int SPEED_W     = 16;
   localparam int CSR_IDX_W   = 2;

   localparam int MUL_STEPS = COUNT_W;
   localparam int DIV_STEPS = DATA_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = SCALE_W'(864000);
   localparam logic [DATA_W-1:0]  SPEED_NUM_RST   = DATA_W'(150796447);
   localparam logic [DATA_W-1:0]  INIT_HP_RST     = DATA_W'(250000);

   localparam logic [COUNT_W-1:0] ANGLE_MAX     = COUNT_W'(360);
   localparam logic [COUNT_W-1:0] PRESET_OFFSET = COUNT_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_SCALE = 2'd0,
      CSR_SPEED_NUM   = 2'd1,
      CSR_INIT_HP     = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_EVENT  = 2'd1,
      OP_PRESET = 2'd2,
      OP_START  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== src/rase_req_if.sv =====
interface rase_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          op;
   logic [rase_pkg::STAMP_WIDTH-1:0]    timestamp;
   logic [rase_pkg::ANGLE_W-1:0]        preset_angle;

   modport source (output valid, output op, output timestamp, output preset_angle,
                   input ready);
   modport sink   (input valid, input op, input timestamp, input preset_angle,
                   output ready);
endinterface

// ===== src/rase_rsp_if.sv =====
interface rase_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rase_pkg::ANGLE_W-1:0]  angle;
   logic [rase_pkg::SPEED_W-1:0]  speed;

   modport source (output valid, output angle, output speed, input ready);
   modport sink   (input valid, input angle, input speed, output ready);
endinterface

// ===== src/rase_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, product mod 2^32.
module rase_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rase_pkg::DATA_W-1:0]         mcand,
   input  logic [rase_pkg::COUNT_W-1:0]        mplier,
   output logic                                done,
   output logic [rase_pkg::DATA_W-1:0]         product
);

   logic [rase_pkg::DATA_W-1:0]    acc_ff, acc_in;
   logic [rase_pkg::DATA_W-1:0]    mcand_ff, mcand_in;
   logic [rase_pkg::COUNT_W-1:0]   mplier_ff, mplier_in;
   logic [rase_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[rase_pkg::DATA_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[rase_pkg::COUNT_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == rase_pkg::MUL_CNT_W'(rase_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/rase_div.sv =====
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
module rase_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rase_pkg::DATA_W-1:0]   dividend,
   input  logic [rase_pkg::DATA_W-1:0]   divisor,
   output logic                          done,
   output logic [rase_pkg::DATA_W-1:0]   quotient
);

   logic [rase_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [rase_pkg::DATA_W-1:0]    quo_ff, quo_in;
   logic [rase_pkg::DATA_W-1:0]    dsr_ff, dsr_in;
   logic [rase_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [rase_pkg::DATA_W:0]      shifted;
   logic [rase_pkg::DATA_W:0]      diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[rase_pkg::DATA_W-1]};
      diff     = shifted - {1'b0, dsr_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[rase_pkg::DATA_W]) begin
            rem_in = diff[rase_pkg::DATA_W-1:0];
         end else begin
            rem_in = shifted[rase_pkg::DATA_W-1:0];
         end
         quo_in = {quo_ff[rase_pkg::DATA_W-2:0], ~diff[rase_pkg::DATA_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rase_pkg::DIV_CNT_W'(rase_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/rotor_angle_speed_estimator_unit.sv =====
// Channel   Direction  Contents
// req_if    in         op, timestamp, preset_angle
// rsp_if    out        angle, speed (one transaction per tick only)
// csr_*     in         write enable, index, data
//
// Tick and preset run a serial multiply then a serial divide; no new request is taken
// until the unit is back in idle. Event and start update their registers on accept.
// Synchronous active-high reset loads register defaults; half period gets its default.
// A finished tick waits in the done state while the output register is full and not being read.
module rotor_angle_speed_estimator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   rase_req_if.sink                              req_if,
   rase_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [rase_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rase_pkg::DATA_W-1:0]           csr_wdata
);

   rase_pkg::state_type              state_ff, state_in;
   rase_pkg::op_type                 op_ff, op_in;
   rase_pkg::op_type                 req_op;

   logic [rase_pkg::SCALE_W-1:0]     scale_ff;
   logic [rase_pkg::DATA_W-1:0]      num_ff;

   logic [rase_pkg::COUNT_W-1:0]     tc_ff, tc_in;
   logic [rase_pkg::DATA_W-1:0]      hp_ff, hp_in;
   logic [rase_pkg::STAMP_WIDTH-1:0] last_ff, last_in;
   logic                             skip_ff, skip_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rase_pkg::ANGLE_W-1:0]     angle_ff, angle_in;
   logic [rase_pkg::SPEED_W-1:0]     speed_ff, speed_in;

   logic                             req_ready;
   logic                             req_fire;
   logic                             out_free;
   logic                             load_out;
   logic                             mul_start;
   logic                             mul_done;
   logic [rase_pkg::DATA_W-1:0]      mul_a;
   logic [rase_pkg::COUNT_W-1:0]     mul_b;
   logic [rase_pkg::COUNT_W-1:0]     tc_inc;
   logic [rase_pkg::DATA_W-1:0]      product;
   logic                             div_a_done;
   logic                             div_s_done;
   logic [rase_pkg::DATA_W-1:0]      div_a_dsr;
   logic [rase_pkg::DATA_W-1:0]      quo_a;
   logic [rase_pkg::DATA_W-1:0]      quo_s;
   logic                             div_s_start;

   assign req_op = rase_pkg::op_type'(req_if.op);
   assign tc_inc = tc_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rase_pkg::ST_IDLE: begin
            if (req_fire && (req_op == rase_pkg::OP_TICK || req_op == rase_pkg::OP_PRESET)) begin
               state_in = rase_pkg::ST_MUL;
            end
         end
         rase_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = rase_pkg::ST_DIV;
            end
         end
         rase_pkg::ST_DIV: begin
            if (div_a_done && (op_ff != rase_pkg::OP_TICK || div_s_done)) begin
               state_in = rase_pkg::ST_DONE;
            end
         end
         rase_pkg::ST_DONE: begin
            if (op_ff != rase_pkg::OP_TICK || out_free) begin
               state_in = rase_pkg::ST_IDLE;
            end
         end
         default: state_in = rase_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      mul_start   = 1'b0;
      div_s_start = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         rase_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_if.valid &&
                        (req_op == rase_pkg::OP_TICK || req_op == rase_pkg::OP_PRESET);
         end
         rase_pkg::ST_MUL: begin
            div_s_start = mul_done && (op_ff == rase_pkg::OP_TICK);
         end
         rase_pkg::ST_DIV: begin
         end
         rase_pkg::ST_DONE: begin
            load_out = (op_ff == rase_pkg::OP_TICK) && out_free;
         end
         default: begin
         end
      endcase
   end

   assign req_if.ready = req_ready;
   assign req_fire     = req_if.valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign mul_a = (req_op == rase_pkg::OP_TICK) ?
                  {{(rase_pkg::DATA_W-rase_pkg::SCALE_W){1'b0}}, scale_ff} : hp_ff;
   assign mul_b = (req_op == rase_pkg::OP_TICK) ? tc_inc :
                  {{(rase_pkg::COUNT_W-rase_pkg::ANGLE_W){1'b0}}, req_if.preset_angle};

   assign div_a_dsr = (op_ff == rase_pkg::OP_TICK) ? hp_ff :
                      {{(rase_pkg::DATA_W-rase_pkg::SCALE_W){1'b0}}, scale_ff};

   rase_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (product)
   );

   // angle (or preset count) quotient
   rase_div u_div_angle (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_done),
      .dividend (product),
      .divisor  (div_a_dsr),
      .done     (div_a_done),
      .quotient (quo_a)
   );

   // speed quotient, runs alongside the angle divide on a tick
   rase_div u_div_speed (
      .clock    (clock),
      .reset    (reset),
      .start    (div_s_start),
      .dividend (num_ff),
      .divisor  (hp_ff),
      .done     (div_s_done),
      .quotient (quo_s)
   );

   // datapath
   always_comb begin
      op_in        = op_ff;
      tc_in        = tc_ff;
      hp_in        = hp_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff;
      angle_in     = angle_ff;
      speed_in     = speed_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         op_in = req_op;
         case (req_op)
            rase_pkg::OP_TICK: begin
               tc_in = tc_inc;
            end
            rase_pkg::OP_EVENT: begin
               hp_in   = rase_pkg::DATA_W'(req_if.timestamp - last_ff);
               last_in = req_if.timestamp;
               if (skip_ff) begin
                  tc_in   = '0;
                  skip_in = 1'b0;
               end else begin
                  skip_in = 1'b1;
               end
            end
            rase_pkg::OP_PRESET: begin
            end
            rase_pkg::OP_START: begin
               last_in = req_if.timestamp;
               tc_in   = '0;
            end
            default: begin
            end
         endcase
      end

      if (state_ff == rase_pkg::ST_DONE && op_ff == rase_pkg::OP_PRESET) begin
         tc_in = quo_a[rase_pkg::COUNT_W-1:0] + rase_pkg::PRESET_OFFSET;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         speed_in     = quo_s[rase_pkg::SPEED_W-1:0];
         if (quo_a[rase_pkg::COUNT_W-1:0] > rase_pkg::ANGLE_MAX) begin
            angle_in = rase_pkg::ANGLE_MAX[rase_pkg::ANGLE_W-1:0];
            tc_in    = '0;
         end else begin
            angle_in = quo_a[rase_pkg::ANGLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rase_pkg::ST_IDLE;
         op_ff        <= rase_pkg::OP_TICK;
         tc_ff        <= '0;
         hp_ff        <= rase_pkg::INIT_HP_RST;
         last_ff      <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= rase_pkg::ANGLE_SCALE_RST;
         num_ff       <= rase_pkg::SPEED_NUM_RST;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         tc_ff        <= tc_in;
         hp_ff        <= hp_in;
         last_ff      <= last_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (rase_pkg::csr_idx_type'(csr_index))
               rase_pkg::CSR_ANGLE_SCALE: scale_ff <= csr_wdata[rase_pkg::SCALE_W-1:0];
               rase_pkg::CSR_SPEED_NUM:   num_ff   <= csr_wdata;
               rase_pkg::CSR_INIT_HP: begin
                  // writes are dropped; reset restores half period to its fixed default
               end
               default: begin
               end
            endcase
         end
      end
      angle_ff <= angle_in;
      speed_ff <= speed_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.angle = angle_ff;
   assign rsp_if.speed = speed_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import rase_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index, writes are dropped
   localparam int SETTLE_CYCLES = 80;    // covers the serial multiply/divide of a preset
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 220;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [SPEED_W-1:0] speed;
   } reading_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   rase_req_if req_bus ();
   rase_rsp_if rsp_bus ();

   rotor_angle_speed_estimator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // estimator state as the testbench sees it
   logic [SCALE_W-1:0] est_scale;
   logic [DATA_W-1:0]  est_speed_num;
   logic [DATA_W-1:0]  est_init_hp;
   logic [DATA_W-1:0]  est_half_period;
   logic [DATA_W-1:0]  est_last_stamp;
   logic [COUNT_W-1:0] est_ticks;
   logic               est_skip;

   reading_type       pending_readings[$];
   int                err_count   = 0;
   int                idle_cycles = 0;
   bit                quick_send;
   bit                quick_recv;
   logic [DATA_W-1:0] stamp_now;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one input transaction to the estimator state; returns 1 when a reading results.
   function automatic bit rotor_step(input op_type op, input logic [DATA_W-1:0] ts,
                                     input logic [ANGLE_W-1:0] pa, output reading_type res);
      logic [63:0]       wide;
      logic [DATA_W-1:0] quo;
      res = '0;
      case (op)
         OP_TICK: begin
            est_ticks = est_ticks + 1'b1;
            wide = 64'(est_scale) * 64'(est_ticks);
            quo = (est_half_period == '0) ? '1 : wide[DATA_W-1:0] / est_half_period;
            if (quo[COUNT_W-1:0] > ANGLE_MAX) begin
               res.angle = ANGLE_W'(ANGLE_MAX);
               est_ticks = '0;
            end else begin
               res.angle = quo[ANGLE_W-1:0];
            end
            quo = (est_half_period == '0) ? '1 : est_speed_num / est_half_period;
            res.speed = quo[SPEED_W-1:0];
            return 1'b1;
         end
         OP_EVENT: begin
            est_half_period = ts - est_last_stamp;
            est_last_stamp = ts;
            if (est_skip) begin
               est_ticks = '0;
               est_skip = 1'b0;
            end else begin
               est_skip = 1'b1;
            end
         end
         OP_PRESET: begin
            wide = 64'(pa) * 64'(est_half_period);
            quo = (est_scale == '0) ? '1 : wide[DATA_W-1:0] / DATA_W'(est_scale);
            est_ticks = quo[COUNT_W-1:0] + PRESET_OFFSET;
         end
         default: begin
            est_last_stamp = ts;
            est_ticks = '0;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic send_item(input op_type op, input logic [DATA_W-1:0] ts,
                            input logic [ANGLE_W-1:0] pa);
      int          gap;
      reading_type res;
      gap = quick_send ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.timestamp    <= ts;
      req_bus.preset_angle <= pa;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (rotor_step(op, ts, pa, res))
         pending_readings.push_back(res);
   endtask

   // Drop valid, let every reading come back, then give a trailing preset time to finish.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ANGLE_SCALE: est_scale     = val[SCALE_W-1:0];
         CSR_SPEED_NUM:   est_speed_num = val;
         CSR_INIT_HP:     est_init_hp   = val;   // recorded only; the estimator drops this write
         default: ;
      endcase
   endtask

   task automatic test_reset_state();
      send_item(OP_TICK, '0, '0);
      send_item(OP_TICK, '1, '1);
   endtask

   task automatic test_zero_period();
      send_item(OP_START, '0, '0);
      send_item(OP_EVENT, '0, '0);       // same stamp twice: half period of zero
      send_item(OP_TICK, '0, '0);
      send_item(OP_PRESET, '0, 9'd200);
      send_item(OP_TICK, '0, '0);
   endtask

   task automatic test_preset_range();
      send_item(OP_EVENT, 32'd250000, '0);
      send_item(OP_PRESET, '0, 9'd0);
      send_item(OP_TICK, '0, '0);
      send_item(OP_PRESET, '0, 9'd360);
      send_item(OP_TICK, '0, '0);
      send_item(OP_PRESET, '0, 9'd511);  // above 360, used as is
      send_item(OP_TICK, '0, '0);
      send_item(OP_START, 32'hFFFF_FFFF, '0);
      send_item(OP_EVENT, 32'h0000_0010, '0);  // stamp wraps
      send_item(OP_TICK, '0, '0);
   endtask

   task automatic test_count_wrap();
      quiesce();
      write_csr(CSR_ANGLE_SCALE, 32'hA500_0001);
      send_item(OP_START, '0, '0);
      send_item(OP_EVENT, 32'd65533, '0);
      send_item(OP_PRESET, '0, 9'd1);    // counter lands on 16'hFFFF
      send_item(OP_TICK, '0, '0);
      send_item(OP_TICK, '0, '0);
   endtask

   task automatic test_random_phase(input logic [SCALE_W-1:0] scale,
                                    input logic [DATA_W-1:0] spd,
                                    input logic [DATA_W-1:0] init_hp, input int count);
      int unsigned       pick;
      logic [DATA_W-1:0] delta;
      int                sent;
      quiesce();
      write_csr(CSR_ANGLE_SCALE, {8'($urandom), scale});
      write_csr(CSR_SPEED_NUM, spd);
      write_csr(CSR_INIT_HP, init_hp);
      write_csr(CSR_SPARE, $urandom);
      for (sent = 0; sent < count; sent++) begin
         if (sent % 40 == 0) begin
            quick_send = ($urandom_range(0, 3) == 0);
            quick_recv = ($urandom_range(0, 3) == 0);
         end
         // mostly periods that put 1 to 300 ticks into one half period
         case ($urandom_range(0, 9))
            0:       delta = '0;
            1:       delta = $urandom_range(1, 255);
            2:       delta = $urandom;
            default: delta = DATA_W'((64'(est_scale) * $urandom_range(1, 300)) / 360);
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            send_item(OP_TICK, $urandom, 9'($urandom));
         end else if (pick < 78) begin
            stamp_now = stamp_now + delta;
            send_item(OP_EVENT, stamp_now, 9'($urandom));
         end else if (pick < 90) begin
            send_item(OP_PRESET, $urandom, ($urandom_range(0, 9) == 0) ?
                      9'($urandom_range(361, 511)) : 9'($urandom_range(0, 360)));
         end else begin
            stamp_now = ($urandom_range(0, 1) == 0) ? $urandom : stamp_now + delta;
            send_item(OP_START, stamp_now, 9'($urandom));
         end
         if ($urandom_range(0, 59) == 0)
            quiesce();
      end
      quick_send = 1'b0;
      quick_recv = 1'b0;
   endtask

   // result side: random stall before each transaction unless quick_recv is set, then check against the oldest reading
   initial begin
      reading_type want;
      int          stall;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = quick_recv ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_readings.size() == 0) begin
            err_count++;
            $display("%0t: unexpected reading: expected none, actual angle %0d speed %0d",
                     $time, rsp_bus.angle, rsp_bus.speed);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_bus.angle !== want.angle) begin
               err_count++;
               $display("%0t: angle mismatch: expected %0d, actual %0d",
                        $time, want.angle, rsp_bus.angle);
            end
            if (rsp_bus.speed !== want.speed) begin
               err_count++;
               $display("%0t: speed mismatch: expected %0d, actual %0d",
                        $time, want.speed, rsp_bus.speed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_ANGLE_SCALE;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_TICK;
      req_bus.timestamp    <= '0;
      req_bus.preset_angle <= '0;
      est_scale       = ANGLE_SCALE_RST;
      est_speed_num   = SPEED_NUM_RST;
      est_init_hp     = INIT_HP_RST;
      est_half_period = INIT_HP_RST;
      est_last_stamp  = '0;
      est_ticks       = '0;
      est_skip        = 1'b0;
      quick_send      = 1'b0;
      quick_recv      = 1'b0;
      stamp_now       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_zero_period();
      test_preset_range();
      test_count_wrap();
      test_random_phase(ANGLE_SCALE_RST, SPEED_NUM_RST, INIT_HP_RST, PHASE_ITEMS);
      test_random_phase(24'd1, 32'd1, 32'd1, PHASE_ITEMS);
      test_random_phase(24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PHASE_ITEMS);
      test_random_phase(24'($urandom_range(1, 24'hFF_FFFF)), $urandom | 32'd1, $urandom,
                        PHASE_ITEMS);
      test_random_phase(24'($urandom_range(1, 24'hFF_FFFF)), $urandom | 32'd1, $urandom,
                        PHASE_ITEMS);
      quiesce();

      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
